/* hw/rtl/wss_pkg.sv */
// ----------------------------------------------------------------------------
// wss_pkg: shared types and constants of the wildcard signature scanner
// widths, wildcard code, register indexes, state codes and the cell
// control struct used by the top level and the matcher cells
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 7;
    localparam int STEP_W      = 4;
    localparam int ADDR_W      = 64;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int NUM_MOD     = (1 << STEP_W) - 1;

    localparam logic [BYTE_W-1:0] WILDCARD = 8'h2A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_ALIGN_STEP     = 2'd1,
        CFG_REGION_BASE    = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PREP  = 3'b010,
        ST_ALIGN = 3'b100
    } state_t;

    typedef struct packed {
        logic shift_win;
        logic clr_win;
        logic rotate;
        logic load;
        logic in_use;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/wss_cell.sv */
// ----------------------------------------------------------------------------
// wss_cell: one matcher cell
// holds one window byte and one pattern byte of the rotating pattern ring,
// compares the pattern byte with the entering byte and passes both on to its neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module wss_cell (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire wss_pkg::cell_ctrl_t ctrl,
    input  wire [wss_pkg::BYTE_W-1:0] win_in,
    output logic [wss_pkg::BYTE_W-1:0] win_out,
    input  wire [wss_pkg::BYTE_W-1:0] pat_nb,
    output logic [wss_pkg::BYTE_W-1:0] pat_out,
    input  wire [wss_pkg::BYTE_W-1:0] load_data,
    output logic                     ok
);
    import wss_pkg::*;

    logic [BYTE_W-1:0] win_reg;
    logic [BYTE_W-1:0] win_next;
    logic [BYTE_W-1:0] pat_reg;
    logic [BYTE_W-1:0] pat_next;

    // window byte, cleared at end of region
    always_comb
    begin
        win_next = win_reg;
        if (ctrl.clr_win)
        begin
            win_next = '0;
        end
        else if (ctrl.shift_win)
        begin
            win_next = win_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    // pattern ring byte, no reset
    always_comb
    begin
        pat_next = pat_reg;
        if (ctrl.rotate)
        begin
            pat_next = pat_nb;
        end
        else if (ctrl.load)
        begin
            pat_next = load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    // compare against the byte entering this cell
    assign ok      = !ctrl.in_use || (pat_reg == WILDCARD) || (pat_reg == win_in);
    assign win_out = win_reg;
    assign pat_out = pat_reg;

endmodule

`default_nettype wire

/* hw/rtl/wildcard_signature_scanner.sv */
// ----------------------------------------------------------------------------
// wildcard_signature_scanner: streaming wildcard byte-pattern search
// loads a pattern one byte per transaction, then scans a region one byte per
// transaction and reports the first aligned match address, or not found
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | cmd, pattern_index, data_byte, last_byte
//  out     | out_valid / out_ready| found, match_address
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  one input transaction per cycle, loads and scans alike, as long as no
//  realignment runs and the output register is empty or being drained; a
//  result appears in the cycle after the scanned byte that causes it
//  after a configuration write in_ready stays low through PREP and ALIGN: the
//  pattern ring rotates one cell per cycle to line up with the new length,
//  and the length remainder modulo the step is found by repeated subtraction
//  reset is asynchronous; no clearing pass, the pattern ring is undefined
//  until loaded and the scan window resets to zero at once
//  a stalled result holds its payload until out_ready
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_signature_scanner (
    input  wire                           clk,
    input  wire                           rst_n,
    // input item channel
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire                           cmd,
    input  wire [wss_pkg::PAT_IDX_W-1:0]  pattern_index,
    input  wire [wss_pkg::BYTE_W-1:0]     data_byte,
    input  wire                           last_byte,
    // result channel
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic                          found,
    output logic [wss_pkg::ADDR_W-1:0]    match_address,
    // configuration write channel
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [wss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [wss_pkg::ADDR_W-1:0]     cfg_data
);
    import wss_pkg::*;

    // configuration registers
    logic [LEN_W-1:0]   pattern_length_reg;
    logic [LEN_W-1:0]   pattern_length_next;
    logic [STEP_W-1:0]  align_step_reg;
    logic [STEP_W-1:0]  align_step_next;
    logic [ADDR_W-1:0]  region_base_reg;
    logic [ADDR_W-1:0]  region_base_next;

    // control state
    state_t             state_reg;
    state_t             state_next;
    logic [PAT_IDX_W-1:0] base_reg;      // ring offset: cell k holds pattern[base - k]
    logic [PAT_IDX_W-1:0] base_next;
    logic [PAT_IDX_W-1:0] rem_reg;       // (len - 1) mod step
    logic [PAT_IDX_W-1:0] rem_next;
    logic [ADDR_W-1:0]  basem_reg;       // region_base - (len - 1)
    logic [ADDR_W-1:0]  basem_next;
    logic [ADDR_W-1:0]  bytes_seen_reg;
    logic [ADDR_W-1:0]  bytes_seen_next;
    logic               reported_reg;
    logic               reported_next;
    logic [STEP_W-1:0]  pm_reg  [NUM_MOD];  // byte position modulo 1..15
    logic [STEP_W-1:0]  pm_next [NUM_MOD];

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               found_reg;
    logic [ADDR_W-1:0]  match_address_reg;

    // datapath
    logic                 in_acc;
    logic                 scan_acc;
    logic                 load_acc;
    logic                 cfg_acc;
    logic                 rot_en;
    logic [LEN_W-1:0]     len_eff;
    logic [PAT_IDX_W-1:0] lenm1;
    logic [STEP_W-1:0]    step_eff;
    logic [STEP_W-1:0]    pm_sel;
    logic [PAT_IDX_W-1:0] wr_addr;
    logic                 pos_fits;
    logic                 aligned;
    logic                 all_ok;
    logic                 hit;
    logic                 miss_end;
    logic [ADDR_W-1:0]    hit_addr;

    // cell chain
    cell_ctrl_t         cell_ctrl [MAX_PATTERN];
    logic [BYTE_W-1:0]  win_in    [MAX_PATTERN];
    logic [BYTE_W-1:0]  win_out   [MAX_PATTERN];
    logic [BYTE_W-1:0]  pat_out   [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_ok;

    // handshakes
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_acc    = in_valid && in_ready;
    assign scan_acc  = in_acc && cmd;
    assign load_acc  = in_acc && !cmd;

    // effective length and step: zero means one, length saturates
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (pattern_length_reg > LEN_W'(MAX_PATTERN))
        begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_eff = pattern_length_reg;
        end
        step_eff = (align_step_reg == '0) ? STEP_W'(1) : align_step_reg;
    end

    assign lenm1   = PAT_IDX_W'(len_eff - LEN_W'(1));
    assign wr_addr = base_reg - pattern_index;

    // configuration writes
    always_comb
    begin
        pattern_length_next = pattern_length_reg;
        align_step_next     = align_step_reg;
        region_base_next    = region_base_reg;
        if (cfg_acc)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PATTERN_LENGTH: pattern_length_next = cfg_data[LEN_W-1:0];
                CFG_ALIGN_STEP:     align_step_next     = cfg_data[STEP_W-1:0];
                CFG_REGION_BASE:    region_base_next    = cfg_data;
                default:            ;
            endcase
        end
    end

    // realignment sequencer: ring rotation and remainder after any config write
    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        rem_next   = rem_reg;
        basem_next = basem_reg;
        rot_en     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_PREP:
            begin
                rem_next   = lenm1;
                basem_next = region_base_reg - ADDR_W'(lenm1);
                state_next = ST_ALIGN;
            end
            ST_ALIGN:
            begin
                if (base_reg != lenm1)
                begin
                    rot_en    = 1'b1;
                    base_next = base_reg - PAT_IDX_W'(1);
                end
                if (rem_reg >= PAT_IDX_W'(step_eff))
                begin
                    rem_next = rem_reg - PAT_IDX_W'(step_eff);
                end
                else if (base_reg == lenm1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_acc)
        begin
            state_next = ST_PREP;
        end
    end

    // match decision for the byte being scanned
    assign pm_sel   = pm_reg[step_eff - STEP_W'(1)];
    assign pos_fits = bytes_seen_reg >= ADDR_W'(lenm1);
    assign aligned  = pm_sel == rem_reg[STEP_W-1:0] && rem_reg < PAT_IDX_W'(step_eff);
    assign all_ok   = &cell_ok;
    assign hit      = scan_acc && !reported_reg && pos_fits && aligned && all_ok;
    assign miss_end = scan_acc && last_byte && !reported_reg && !hit;
    assign hit_addr = basem_reg + bytes_seen_reg;

    // region bookkeeping
    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        reported_next   = reported_reg;
        for (int i = 0; i < NUM_MOD; i++)
        begin
            pm_next[i] = pm_reg[i];
        end
        if (scan_acc)
        begin
            if (last_byte)
            begin
                bytes_seen_next = '0;
                reported_next   = 1'b0;
                for (int i = 0; i < NUM_MOD; i++)
                begin
                    pm_next[i] = '0;
                end
            end
            else
            begin
                bytes_seen_next = bytes_seen_reg + ADDR_W'(1);
                reported_next   = reported_reg || hit;
                for (int i = 0; i < NUM_MOD; i++)
                begin
                    pm_next[i] = (pm_reg[i] == STEP_W'(i)) ? '0 : pm_reg[i] + STEP_W'(1);
                end
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (hit || miss_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= LEN_W'(1);
            align_step_reg     <= STEP_W'(4);
            region_base_reg    <= '0;
            state_reg          <= ST_IDLE;
            base_reg           <= '0;
            rem_reg            <= '0;
            basem_reg          <= '0;
            bytes_seen_reg     <= '0;
            reported_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            for (int i = 0; i < NUM_MOD; i++)
            begin
                pm_reg[i] <= '0;
            end
        end
        else
        begin
            pattern_length_reg <= pattern_length_next;
            align_step_reg     <= align_step_next;
            region_base_reg    <= region_base_next;
            state_reg          <= state_next;
            base_reg           <= base_next;
            rem_reg            <= rem_next;
            basem_reg          <= basem_next;
            bytes_seen_reg     <= bytes_seen_next;
            reported_reg       <= reported_next;
            out_valid_reg      <= out_valid_next;
            for (int i = 0; i < NUM_MOD; i++)
            begin
                pm_reg[i] <= pm_next[i];
            end
        end
    end

    // result payload, only loaded when a result is produced
    always_ff @(posedge clk)
    begin
        if (hit || miss_end)
        begin
            found_reg         <= hit;
            match_address_reg <= hit ? hit_addr : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = match_address_reg;

    // chain of matcher cells: window shifts toward higher cells, pattern ring
    // rotates toward lower cells
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        localparam int NB = (k + 1) % MAX_PATTERN;

        if (k == 0)
        begin : g_head
            assign win_in[k] = data_byte;
        end
        else
        begin : g_body
            assign win_in[k] = win_out[k-1];
        end

        assign cell_ctrl[k].shift_win = scan_acc;
        assign cell_ctrl[k].clr_win   = scan_acc && last_byte;
        assign cell_ctrl[k].rotate    = rot_en;
        assign cell_ctrl[k].load      = load_acc && (wr_addr == PAT_IDX_W'(k));
        assign cell_ctrl[k].in_use    = PAT_IDX_W'(k) <= lenm1;

        wss_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[k]),
            .win_in    (win_in[k]),
            .win_out   (win_out[k]),
            .pat_nb    (pat_out[NB]),
            .pat_out   (pat_out[k]),
            .load_data (data_byte),
            .ok        (cell_ok[k])
        );
    end

endmodule

`default_nettype wire

/* hw/rtl/wss_checker.sv */
// ----------------------------------------------------------------------------
// wss_checker: port-level checks of the wildcard signature scanner
// watches the handshakes and results over time, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module wss_checker (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    input  wire                           in_ready,
    input  wire                           cmd,
    input  wire                           out_valid,
    input  wire                           out_ready,
    input  wire                           found,
    input  wire [wss_pkg::ADDR_W-1:0]     match_address
);
    import wss_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_address))
        else $error("result changed while stalled");

    // not found always carries a zero address
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_address == '0)
        else $error("not found result with nonzero address");

    // a fresh result follows a scan transaction
    a_fresh_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready && cmd))
        else $error("result without a scan transaction");

    // a pattern load never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !cmd |=> !out_valid)
        else $error("result after a pattern load");

endmodule

bind wildcard_signature_scanner wss_checker u_wss_checker (.*);

`default_nettype wire
